// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the shoreline mask block.
// Uses clk and arst_n of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expression must hold at every clock edge out of reset
`define CHK_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CHK_ALWAYS(lbl, expr, msg)
`define CHK_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/scdm_pkg.sv =====
// Package for the signed chamfer distance mask: grid sizes, codes, types.
// No dependencies.
`timescale 1ns / 1ps
package scdm_pkg;
	localparam int GRID_SIDE = 64;
	localparam int CELLS     = GRID_SIDE * GRID_SIDE;
	localparam int AW        = $clog2(CELLS);
	localparam int CW        = $clog2(GRID_SIDE);

	localparam logic [15:0] DIST_MAX   = 16'hFFFF;
	localparam logic [8:0]  STEP_ORTHO = 9'd256;
	localparam logic [8:0]  STEP_DIAG  = 9'd362;

	// transform taps: own cell, then the four neighbors of the pass
	localparam logic [2:0] TAP_SELF   = 3'd0;
	localparam logic [2:0] TAP_ROW    = 3'd1;
	localparam logic [2:0] TAP_COL    = 3'd2;
	localparam logic [2:0] TAP_DIAG_A = 3'd3;
	localparam logic [2:0] TAP_DIAG_B = 3'd4;
	localparam logic [2:0] TAP_LAST   = TAP_DIAG_B;
	localparam logic [2:0] RTAP_LAST  = 3'd3;

	localparam logic MODE_LOAD = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE, ST_T_RD, ST_T_WR, ST_R_RD, ST_R_ACC, ST_R_SCALE, ST_R_DIV, ST_R_OUT
	} state_t;

	typedef struct packed {
		logic       load_we;
		logic       t_start_fwd;
		logic       t_start_bwd;
		logic       t_bwd;
		logic       t_rd;
		logic [2:0] t_tap;
		logic       t_acc;
		logic       t_wr;
		logic       r_start;
		logic       r_rd;
		logic [1:0] r_tap;
		logic       r_acc;
		logic       r_scale;
		logic       r_div;
		logic       r_out;
	} cmd_t;

	typedef struct packed {
		logic last_cell;
	} sts_t;
endpackage

// ===== rtl/scdm_ctrl.sv =====
// Controller state machine for the shoreline mask: sequences loads,
// the two transform passes and texel reads. Depends on scdm_pkg.
`timescale 1ns / 1ps
module scdm_ctrl import scdm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic mode,
	input  logic last_tile,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);
	state_t     state_q, state_d;
	logic [2:0] tap_q, tap_d;
	logic       bwd_q, bwd_d;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= TAP_SELF;
			bwd_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			tap_q   <= tap_d;
			bwd_q   <= bwd_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		tap_d     = tap_q;
		bwd_d     = bwd_q;
		cmd       = '0;
		cmd.t_bwd = bwd_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					tap_d = TAP_SELF;
					if (mode == MODE_LOAD) begin
						cmd.load_we = 1'b1;
						if (last_tile) begin
							cmd.t_start_fwd = 1'b1;
							bwd_d   = 1'b0;
							state_d = ST_T_RD;
						end
					end else begin
						cmd.r_start = 1'b1;
						state_d     = ST_R_RD;
					end
				end
			end
			ST_T_RD: begin
				cmd.t_rd  = 1'b1;
				cmd.t_tap = tap_q;
				cmd.t_acc = (tap_q != TAP_SELF);
				if (tap_q == TAP_LAST) state_d = ST_T_WR;
				else tap_d = tap_q + 3'd1;
			end
			ST_T_WR: begin
				cmd.t_acc = 1'b1;
				cmd.t_wr  = 1'b1;
				tap_d     = TAP_SELF;
				state_d   = ST_T_RD;
				if (sts.last_cell) begin
					if (!bwd_q) begin
						cmd.t_start_bwd = 1'b1;
						bwd_d = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_R_RD: begin
				cmd.r_rd  = 1'b1;
				cmd.r_tap = tap_q[1:0];
				cmd.r_acc = (tap_q != TAP_SELF);
				if (tap_q == RTAP_LAST) state_d = ST_R_ACC;
				else tap_d = tap_q + 3'd1;
			end
			ST_R_ACC: begin
				cmd.r_acc = 1'b1;
				state_d   = ST_R_SCALE;
			end
			ST_R_SCALE: begin
				cmd.r_scale = 1'b1;
				state_d     = ST_R_DIV;
			end
			ST_R_DIV: begin
				cmd.r_div = 1'b1;
				state_d   = ST_R_OUT;
			end
			ST_R_OUT: begin
				cmd.r_out = 1'b1;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
endmodule

// ===== rtl/scdm_dp.sv =====
// Datapath for the shoreline mask: tile and distance memories, transform
// relaxation, bilinear sum and byte mapping. Depends on scdm_pkg.
`timescale 1ns / 1ps
module scdm_dp import scdm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output sts_t       sts,
	input  logic       tile_is_water,
	input  logic       last_tile,
	input  logic [8:0] texel_x,
	input  logic [8:0] texel_y,
	output logic [7:0] mask_value
);
	localparam logic signed [26:0] S_LIMIT = 27'sd163840;

	logic kind_mem [CELLS];
	logic [15:0] dl_mem [CELLS];
	logic [15:0] dw_mem [CELLS];

	logic [AW-1:0] load_pos_q;
	logic [CW-1:0] x_q, y_q;
	logic [AW-1:0] idx_q;

	logic [AW-1:0] t_addr, r_addr, rd_addr;
	logic          t_nvalid;
	logic [8:0]    t_step;
	logic          kind_rd_q;
	logic [15:0]   dl_rd_q, dw_rd_q;
	logic [2:0]    tap_s1;
	logic          nvalid_s1;
	logic [8:0]    w_s1;
	logic [15:0]   v_dl_q, v_dw_q, v_dl_d, v_dw_d;

	logic [4:0]    fx_q, fy_q;
	logic [AW-1:0] base_q;
	logic [CW+4:0] ax_x, ax_y;
	logic [4:0]    wx, wy;
	logic [9:0]    wprod;
	logic signed [26:0] sum_q;
	logic signed [16:0] sdist;
	logic signed [26:0] prod;
	logic signed [26:0] clamped;
	logic [18:0]   shifted;
	logic [26:0]   scaled;
	logic [10:0]   hi_q;
	logic [26:0]   quot;
	logic [7:0]    mask_q;

	function automatic logic [15:0] relax(input logic [15:0] v, input logic [15:0] n,
			input logic [8:0] w);
		logic [16:0] s;
		logic [15:0] c;
		s = {1'b0, n} + {8'b0, w};
		c = s[16] ? DIST_MAX : s[15:0];
		return (c < v) ? c : v;
	endfunction

	// sample coordinate 2m-7 in sixteenths: base tile and weight, edge clamped
	function automatic logic [CW+4:0] axis(input logic [8:0] m);
		logic [9:0] g;
		logic [8:0] b;
		logic [4:0] f;
		g = {m, 1'b0} - 10'd7;
		b = '0;
		f = '0;
		if (m >= 9'd4) begin
			b = {3'b0, g[9:4]};
			f = {1'b0, g[3:0]};
		end
		if (b > 9'(GRID_SIDE - 2)) begin
			b = 9'(GRID_SIDE - 2);
			f = 5'd16;
		end
		return {b[CW-1:0], f};
	endfunction

	// load position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
		end else if (cmd.load_we) begin
			if (last_tile || load_pos_q == AW'(CELLS - 1)) load_pos_q <= '0;
			else load_pos_q <= load_pos_q + AW'(1);
		end
	end

	// raster cursor for the transform passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			idx_q <= '0;
		end else if (cmd.t_start_fwd) begin
			x_q   <= '0;
			y_q   <= '0;
			idx_q <= '0;
		end else if (cmd.t_start_bwd) begin
			x_q   <= CW'(GRID_SIDE - 1);
			y_q   <= CW'(GRID_SIDE - 1);
			idx_q <= AW'(CELLS - 1);
		end else if (cmd.t_wr) begin
			if (!cmd.t_bwd) begin
				idx_q <= idx_q + AW'(1);
				if (x_q == CW'(GRID_SIDE - 1)) begin
					x_q <= '0;
					y_q <= y_q + CW'(1);
				end else begin
					x_q <= x_q + CW'(1);
				end
			end else begin
				idx_q <= idx_q - AW'(1);
				if (x_q == '0) begin
					x_q <= CW'(GRID_SIDE - 1);
					y_q <= y_q - CW'(1);
				end else begin
					x_q <= x_q - CW'(1);
				end
			end
		end
	end

	assign sts.last_cell = cmd.t_bwd ? (x_q == '0 && y_q == '0)
		: (x_q == CW'(GRID_SIDE - 1) && y_q == CW'(GRID_SIDE - 1));

	// neighbor address, validity and step weight for the current tap
	always_comb begin
		t_addr   = idx_q;
		t_nvalid = 1'b0;
		t_step   = STEP_ORTHO;
		unique case (cmd.t_tap)
			TAP_SELF: t_nvalid = 1'b1;
			TAP_ROW: begin
				t_addr   = cmd.t_bwd ? idx_q + AW'(1) : idx_q - AW'(1);
				t_nvalid = cmd.t_bwd ? (x_q != CW'(GRID_SIDE - 1)) : (x_q != '0);
			end
			TAP_COL: begin
				t_addr   = cmd.t_bwd ? idx_q + AW'(GRID_SIDE) : idx_q - AW'(GRID_SIDE);
				t_nvalid = cmd.t_bwd ? (y_q != CW'(GRID_SIDE - 1)) : (y_q != '0);
			end
			TAP_DIAG_A: begin
				t_step   = STEP_DIAG;
				t_addr   = cmd.t_bwd ? idx_q + AW'(GRID_SIDE + 1)
					: idx_q - AW'(GRID_SIDE + 1);
				t_nvalid = cmd.t_bwd
					? (x_q != CW'(GRID_SIDE - 1) && y_q != CW'(GRID_SIDE - 1))
					: (x_q != '0 && y_q != '0);
			end
			TAP_DIAG_B: begin
				t_step   = STEP_DIAG;
				t_addr   = cmd.t_bwd ? idx_q + AW'(GRID_SIDE - 1)
					: idx_q - AW'(GRID_SIDE - 1);
				t_nvalid = cmd.t_bwd
					? (x_q != '0 && y_q != CW'(GRID_SIDE - 1))
					: (x_q != CW'(GRID_SIDE - 1) && y_q != '0);
			end
			default: t_nvalid = 1'b0;
		endcase
	end

	// texel read address and bilinear weight for the current corner
	always_comb begin
		wx     = cmd.r_tap[0] ? fx_q : 5'd16 - fx_q;
		wy     = cmd.r_tap[1] ? fy_q : 5'd16 - fy_q;
		wprod  = {5'b0, wx} * {5'b0, wy};
		r_addr = base_q + AW'(cmd.r_tap[0]) + (cmd.r_tap[1] ? AW'(GRID_SIDE) : AW'(0));
	end

	assign rd_addr = cmd.r_rd ? r_addr : t_addr;

	// memories: one write, one registered read each
	always_ff @(posedge clk) begin
		if (cmd.load_we) kind_mem[load_pos_q] <= tile_is_water;
		if (cmd.t_wr) begin
			dl_mem[idx_q] <= v_dl_d;
			dw_mem[idx_q] <= v_dw_d;
		end
		if (cmd.t_rd || cmd.r_rd) begin
			kind_rd_q <= kind_mem[rd_addr];
			dl_rd_q   <= dl_mem[rd_addr];
			dw_rd_q   <= dw_mem[rd_addr];
		end
	end

	// tap info that travels with the read data
	always_ff @(posedge clk) begin
		if (cmd.t_rd) begin
			tap_s1    <= cmd.t_tap;
			nvalid_s1 <= t_nvalid;
			w_s1      <= t_step;
		end else if (cmd.r_rd) begin
			w_s1 <= wprod[8:0];
		end
	end

	// relaxation of both distances
	always_comb begin
		v_dl_d = v_dl_q;
		v_dw_d = v_dw_q;
		if (tap_s1 == TAP_SELF) begin
			if (cmd.t_bwd) begin
				v_dl_d = dl_rd_q;
				v_dw_d = dw_rd_q;
			end else begin
				v_dl_d = kind_rd_q ? DIST_MAX : 16'd0;
				v_dw_d = kind_rd_q ? 16'd0 : DIST_MAX;
			end
		end else if (nvalid_s1) begin
			v_dl_d = relax(v_dl_q, dl_rd_q, w_s1);
			v_dw_d = relax(v_dw_q, dw_rd_q, w_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.t_acc) begin
			v_dl_q <= v_dl_d;
			v_dw_q <= v_dw_d;
		end
	end

	// texel setup, weighted sum, clamp and byte mapping
	assign ax_x  = axis(texel_x);
	assign ax_y  = axis(texel_y);
	assign sdist = kind_rd_q ? -$signed({1'b0, dl_rd_q}) : $signed({1'b0, dw_rd_q});
	assign prod  = 27'(sdist) * 27'($signed({1'b0, w_s1}));

	always_comb begin
		if (sum_q > S_LIMIT) clamped = S_LIMIT;
		else if (sum_q < -S_LIMIT) clamped = -S_LIMIT;
		else clamped = sum_q;
		shifted = 19'(clamped + S_LIMIT);
		scaled  = {8'b0, shifted} * 27'd255;
		quot    = {16'b0, hi_q} * 27'd52429;
	end

	always_ff @(posedge clk) begin
		if (cmd.r_start) begin
			fx_q   <= ax_x[4:0];
			fy_q   <= ax_y[4:0];
			base_q <= AW'(int'(ax_y[CW+4:5]) * GRID_SIDE + int'(ax_x[CW+4:5]));
			sum_q  <= '0;
		end else if (cmd.r_acc) begin
			sum_q <= sum_q + prod;
		end
		if (cmd.r_scale) hi_q <= scaled[26:16];
		if (cmd.r_div) mask_q <= quot[25:18];
	end

	assign mask_value = mask_q;
endmodule

// ===== rtl/signed_chamfer_distance_mask_top.sv =====
// Top level of the signed chamfer distance shoreline mask.
// Depends on scdm_pkg, scdm_ctrl, scdm_dp and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A command is taken when start is high and busy is low. A tile load without
// last_tile leaves busy low. The load flagged last_tile then runs a forward and
// a backward chamfer pass over the grid, both distances at once, busy high,
// reading the taps of each tile in turn (one read per tap on the single read
// port of the distance memories) and then writing the tile. A texel read stays
// busy through four corner reads, accumulate, clamp and scale, divide, output.
// The result is shown for one cycle with mask_valid high; there is no stall.
module signed_chamfer_distance_mask_top import scdm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       mode,
	input  logic       tile_is_water,
	input  logic       last_tile,
	input  logic [8:0] texel_x,
	input  logic [8:0] texel_y,
	output logic       mask_valid,
	output logic [7:0] mask_value
);
	cmd_t cmd;
	sts_t sts;

	scdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.last_tile (last_tile),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	scdm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.tile_is_water (tile_is_water),
		.last_tile     (last_tile),
		.texel_x       (texel_x),
		.texel_y       (texel_y),
		.mask_value    (mask_value)
	);

	assign mask_valid = cmd.r_out;

	// result beats come only from inside a read sequence, one cycle each
	`CHK_ALWAYS(a_valid_busy, !mask_valid || busy, "result beat outside a read")
	`CHK_NEXT(a_valid_single, mask_valid, !mask_valid, "result beat longer than one cycle")
	`CHK_NEXT(a_read_busy, start && !busy && mode, busy, "read command did not go busy")
	`CHK_NEXT(a_last_busy, start && !busy && !mode && last_tile, busy,
		"last tile did not start the transform")
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the signed chamfer distance shoreline mask: drives tile loads and
// texel reads, predicts every mask byte and compares. Depends on scdm_pkg and the top.
`timescale 1ns / 1ps

// Shoreline mask predictor and scoreboard: tracks tiles and distances, holds
// the mask bytes still due from the block.
class shore_mask_board;
	localparam int SIDE = scdm_pkg::GRID_SIDE;
	localparam int NCELL = scdm_pkg::CELLS;
	localparam longint S_LIM = 163840;

	bit         tile_kind [NCELL];
	bit [15:0]  to_land [NCELL];
	bit [15:0]  to_water [NCELL];
	int         load_pos;
	bit [7:0]   mask_due [$];
	int         errors;

	function void clear();
		load_pos = 0;
		errors = 0;
		mask_due.delete();
	endfunction

	task report_mismatch(string msg);
		errors++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	function bit [15:0] relax(bit [15:0] v, bit [15:0] n, int w);
		int s;
		s = n + w;
		if (s > scdm_pkg::DIST_MAX)
			s = scdm_pkg::DIST_MAX;
		return (s < v) ? s[15:0] : v;
	endfunction

	// forward raster pass then backward pass, weights 256 / 362
	function void chamfer(inout bit [15:0] d [NCELL]);
		int i;
		bit [15:0] v;
		for (int y = 0; y < SIDE; y++)
			for (int x = 0; x < SIDE; x++) begin
				i = y * SIDE + x;
				v = d[i];
				if (x > 0) v = relax(v, d[i-1], scdm_pkg::STEP_ORTHO);
				if (y > 0) v = relax(v, d[i-SIDE], scdm_pkg::STEP_ORTHO);
				if (x > 0 && y > 0) v = relax(v, d[i-SIDE-1], scdm_pkg::STEP_DIAG);
				if (x < SIDE-1 && y > 0) v = relax(v, d[i-SIDE+1], scdm_pkg::STEP_DIAG);
				d[i] = v;
			end
		for (int y = SIDE-1; y >= 0; y--)
			for (int x = SIDE-1; x >= 0; x--) begin
				i = y * SIDE + x;
				v = d[i];
				if (x < SIDE-1) v = relax(v, d[i+1], scdm_pkg::STEP_ORTHO);
				if (y < SIDE-1) v = relax(v, d[i+SIDE], scdm_pkg::STEP_ORTHO);
				if (x < SIDE-1 && y < SIDE-1)
					v = relax(v, d[i+SIDE+1], scdm_pkg::STEP_DIAG);
				if (x > 0 && y < SIDE-1) v = relax(v, d[i+SIDE-1], scdm_pkg::STEP_DIAG);
				d[i] = v;
			end
	endfunction

	function void axis(bit [8:0] m, output int b, output int f);
		int g;
		g = 2 * int'(m) - 7;
		b = 0;
		f = 0;
		if (g >= 0) begin
			b = g >>> 4;
			f = g & 15;
		end
		// edge clamp at the far side
		if (b > SIDE - 2) begin
			b = SIDE - 2;
			f = 16;
		end
	endfunction

	function longint signed_dist(int x, int y);
		int i;
		i = y * SIDE + x;
		return tile_kind[i] ? -longint'(to_land[i]) : longint'(to_water[i]);
	endfunction

	// accepted command beat: update state, queue the mask byte for reads
	function void note_beat(bit mode, bit water, bit last, bit [8:0] tx, bit [8:0] ty);
		int x0, y0, fx, fy;
		longint s;
		if (mode == scdm_pkg::MODE_LOAD) begin
			tile_kind[load_pos] = water;
			load_pos = (load_pos + 1) % NCELL;
			if (last) begin
				load_pos = 0;
				foreach (tile_kind[i]) begin
					to_land[i] = tile_kind[i] ? scdm_pkg::DIST_MAX : 16'd0;
					to_water[i] = tile_kind[i] ? 16'd0 : scdm_pkg::DIST_MAX;
				end
				chamfer(to_land);
				chamfer(to_water);
			end
		end else begin
			axis(tx, x0, fx);
			axis(ty, y0, fy);
			s = signed_dist(x0, y0) * (16 - fx) * (16 - fy)
			  + signed_dist(x0 + 1, y0) * fx * (16 - fy)
			  + signed_dist(x0, y0 + 1) * (16 - fx) * fy
			  + signed_dist(x0 + 1, y0 + 1) * fx * fy;
			if (s < -S_LIM) s = -S_LIM;
			if (s > S_LIM) s = S_LIM;
			mask_due.push_back(8'((255 * (s + S_LIM)) / (2 * S_LIM)));
		end
	endfunction

	task check_mask(bit [7:0] got);
		bit [7:0] want;
		if (mask_due.size() == 0) begin
			report_mismatch($sformatf("mask_value %0d with no read pending", got));
			return;
		end
		want = mask_due.pop_front();
		if (got !== want)
			report_mismatch($sformatf("mask_value %0d, expected %0d", got, want));
	endtask
endclass

module tb_top;
	import scdm_pkg::*;

	localparam logic MODE_READ = 1'b1;
	localparam int QUIET_LIMIT = 200000;
	localparam int TAIL_CYCLES = 40;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       mode;
	logic       tile_is_water;
	logic       last_tile;
	logic [8:0] texel_x;
	logic [8:0] texel_y;
	logic       mask_valid;
	logic [7:0] mask_value;

	shore_mask_board board;
	int idle_pct;
	int quiet;

	signed_chamfer_distance_mask_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .tile_is_water(tile_is_water), .last_tile(last_tile),
		.texel_x(texel_x), .texel_y(texel_y),
		.mask_valid(mask_valid), .mask_value(mask_value)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		if (arst_n && mask_valid) begin
			board.check_mask(mask_value);
			quiet = 0;
		end else begin
			quiet++;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// one command beat, with random idle cycles ahead of it
	task automatic send(bit m, bit w, bit l, bit [8:0] x, bit [8:0] y);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			mode <= 1'($urandom);
			texel_x <= 9'($urandom);
			@(posedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		mode <= m;
		tile_is_water <= w;
		last_tile <= l;
		texel_x <= x;
		texel_y <= y;
		do @(posedge clk); while (busy);
		board.note_beat(m, w, l, x, y);
		quiet = 0;
	endtask

	task automatic load_tile(bit w, bit l);
		send(MODE_LOAD, w, l, 9'($urandom), 9'($urandom));
	endtask

	task automatic read_texel(bit [8:0] x, bit [8:0] y);
		send(MODE_READ, 1'($urandom), 1'($urandom), x, y);
	endtask

	// hold the command side off until every mask byte is back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (board.mask_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic bit [8:0] pick_coord();
		if ($urandom_range(3) == 0)
			return ($urandom_range(1)) ? 9'($urandom_range(8)) : 9'($urandom_range(511, 500));
		return 9'($urandom);
	endfunction

	initial begin
		int n, dens, dx, dy;
		bit [8:0] spots [10];
		board = new();
		board.clear();
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_LOAD;
		tile_is_water = 1'b0;
		last_tile = 1'b0;
		texel_x = '0;
		texel_y = '0;
		quiet = 0;
		idle_pct = 20;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// full grid: water with a round island, a land column on the east edge, land at cell 0
		for (int i = 0; i < CELLS; i++) begin
			dx = (i % GRID_SIDE) - 20;
			dy = (i / GRID_SIDE) - 30;
			load_tile(!((dx * dx + dy * dy <= 100) || (i % GRID_SIDE == GRID_SIDE - 1)
				|| i == 0), i == CELLS - 1);
		end
		// corners, near-edge clamps on both sides, shore texels
		spots = '{9'd0, 9'd3, 9'd4, 9'd5, 9'd160, 9'd240, 9'd507, 9'd508, 9'd510, 9'd511};
		foreach (spots[i])
			read_texel(spots[i], spots[9 - i]);
		read_texel(9'd160, 9'd240);
		read_texel(9'd80, 9'd240);
		read_texel(9'd511, 9'd0);
		drain();

		// uniform water, overrunning the grid so the position wraps
		for (int i = 0; i < CELLS + 5; i++)
			load_tile(1'b1, i == CELLS + 4);
		read_texel(9'd0, 9'd0);
		read_texel(9'd511, 9'd300);
		drain();
		// uniform land
		for (int i = 0; i < CELLS; i++)
			load_tile(1'b0, i == CELLS - 1);
		read_texel(9'd511, 9'd511);
		read_texel(9'd100, 9'd7);
		drain();

		// random rounds: partial reload over the old grid, then reads with stray loads
		for (int r = 0; r < 6; r++) begin
			idle_pct = (r < 2) ? 20 : (r < 4) ? 73 : 0;
			n = $urandom_range(600, 1);
			dens = $urandom_range(100);
			for (int i = 0; i < n; i++)
				load_tile($urandom_range(99) < dens, i == n - 1);
			for (int i = 0; i < 130; i++) begin
				if ($urandom_range(9) == 0)
					load_tile(1'($urandom), 1'b0);
				else
					read_texel(pick_coord(), pick_coord());
			end
			drain();
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.mask_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
